FILE: rtl/core/wvip_pkg.sv
// Package for the two-wheel incremental PID block.
// Holds widths, register indexes, reset values, FSM state and command types.
// No dependencies.
package wvip_pkg;

    localparam int NUM_WHEELS_DEF = 2;

    localparam int VEL_W   = 32;
    localparam int GAIN_W  = 24;
    localparam int LIMIT_W = 15;
    localparam int ACC_W   = 40;
    localparam int DRIVE_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int FRAC_W  = 16;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 24'd26214;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 24'd5243;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 24'd13107;
    localparam logic [GAIN_W-1:0]  SPEED_SCALE_RST = 24'd65536;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd700;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_LEFT_SCALE  = 3'd3,
        CFG_RIGHT_SCALE = 3'd4,
        CFG_DRIVE_LIMIT = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MUL_SCALE,
        MUL_PROP,
        MUL_INTEG,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ERR,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_ACCUM,
        ST_SCALE_OUT,
        ST_DRIVE
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     ld_err;
        logic     sum_clr;
        logic     sum_add;
        logic     acc_upd;
        logic     ld_scaled;
        logic     ld_out;
    } dp_cmd_t;

endpackage

FILE: rtl/core/wvip_ctrl.sv
// Sequencer for the incremental PID block.
// Steps the shared multiplier and update stages; owns both handshakes.
// Depends on wvip_pkg.
module wvip_ctrl
    import wvip_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_SCALE;
            ST_SCALE:     state_next = ST_ERR;
            ST_ERR:       state_next = ST_PROP;
            ST_PROP:      state_next = ST_INTEG;
            ST_INTEG:     state_next = ST_DERIV;
            ST_DERIV:     state_next = ST_ACCUM;
            ST_ACCUM:     state_next = ST_SCALE_OUT;
            ST_SCALE_OUT: state_next = ST_DRIVE;
            ST_DRIVE:     if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MUL_SCALE;
        unique case (state_reg)
            ST_IDLE:      cmd.load_in = in_valid;
            ST_SCALE:     cmd.mul_en = 1'b1;
            ST_ERR:       cmd.ld_err = 1'b1;
            ST_PROP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
            end
            ST_INTEG:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTEG;
                cmd.sum_clr = 1'b1;
            end
            ST_DERIV:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DERIV;
                cmd.sum_add = 1'b1;
            end
            ST_ACCUM:     cmd.acc_upd = 1'b1;
            ST_SCALE_OUT: cmd.ld_scaled = 1'b1;
            ST_DRIVE:     cmd.ld_out = out_free;
            default:      cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

endmodule

FILE: rtl/core/wvip_datapath.sv
// Datapath for the incremental PID block: config registers, per-wheel
// history and accumulators, one shared multiplier, output register.
// Depends on wvip_pkg.
module wvip_datapath
    import wvip_pkg::*;
#(
    parameter int NUM_WHEELS = NUM_WHEELS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        wheel_select,
    input  logic signed [VEL_W-1:0]     target_vel,
    input  logic signed [VEL_W-1:0]     measured_speed,
    output logic                        wheel_out,
    output logic signed [DRIVE_W-1:0]   drive_hundredths
);

    localparam int IDX_W  = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int ERR_W  = PROD_W - FRAC_W + 1;
    localparam int INC_W  = SUM_W - FRAC_W;
    localparam int NACC_W = INC_W + 1;
    localparam int T_W    = ACC_W + 1;
    localparam int V_W    = 48;
    localparam int MAG_W  = V_W - FRAC_W;

    logic [GAIN_W-1:0]  prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [GAIN_W-1:0]  left_scale_reg, right_scale_reg;
    logic [LIMIT_W-1:0] limit_reg;

    logic signed [VEL_W-1:0] e1_reg [NUM_WHEELS];
    logic signed [VEL_W-1:0] e2_reg [NUM_WHEELS];
    logic signed [ACC_W-1:0] acc_reg [NUM_WHEELS];

    logic                    wheel_reg;
    logic signed [VEL_W-1:0] tgt_reg, spd_reg;
    logic signed [VEL_W-1:0] err_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  acc_new_reg;
    logic signed [V_W-1:0]    v_reg;
    logic                     out_wheel_reg;
    logic signed [DRIVE_W-1:0] out_drive_reg;

    logic                     wheel_ok;
    logic [IDX_W-1:0]         idx;
    logic signed [VEL_W-1:0]  e1, e2;
    logic signed [ACC_W-1:0]  acc_old;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic [GAIN_W-1:0]        scale;
    logic signed [ERR_W-1:0]  err_wide;
    logic signed [VEL_W-1:0]  err_sat;
    logic signed [SUM_W-1:0]  sum_total;
    logic signed [NACC_W-1:0] acc_wide;
    logic signed [ACC_W-1:0]  acc_sat;
    logic signed [V_W-1:0]    t_ext;
    logic [V_W-1:0]           v_abs;
    logic [MAG_W-1:0]         mag;
    logic [LIMIT_W-1:0]       mag_clamp;
    logic signed [DRIVE_W-1:0] drive;

    assign wheel_ok = (32'(wheel_reg) < NUM_WHEELS);
    assign idx      = wheel_ok ? IDX_W'(wheel_reg) : '0;
    assign e1       = e1_reg[idx];
    assign e2       = e2_reg[idx];
    assign acc_old  = acc_reg[idx];
    assign scale    = wheel_reg ? right_scale_reg : left_scale_reg;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            left_scale_reg  <= SPEED_SCALE_RST;
            right_scale_reg <= SPEED_SCALE_RST;
            limit_reg       <= DRIVE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                CFG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data;
                CFG_LEFT_SCALE:  left_scale_reg  <= cfg_data;
                CFG_RIGHT_SCALE: right_scale_reg <= cfg_data;
                CFG_DRIVE_LIMIT: limit_reg       <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // shared multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SCALE:
            begin
                mul_a = MUL_A_W'(spd_reg);
                mul_b = signed'({1'b0, scale});
            end
            MUL_PROP:
            begin
                mul_a = MUL_A_W'(err_reg) - MUL_A_W'(e1);
                mul_b = signed'({1'b0, prop_gain_reg});
            end
            MUL_INTEG:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = signed'({1'b0, integ_gain_reg});
            end
            MUL_DERIV:
            begin
                mul_a = MUL_A_W'(err_reg) - (MUL_A_W'(e1) <<< 1) + MUL_A_W'(e2);
                mul_b = signed'({1'b0, deriv_gain_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // error: target minus floor(speed * scale / 2^16), saturated to 32 bits
    always_comb
    begin
        err_wide = ERR_W'(tgt_reg) - ERR_W'(signed'(prod_reg[PROD_W-1:FRAC_W]));
        if (err_wide > ERR_W'(32'sh7FFF_FFFF))
            err_sat = 32'sh7FFF_FFFF;
        else if (err_wide < ERR_W'(32'sh8000_0000))
            err_sat = 32'sh8000_0000;
        else
            err_sat = err_wide[VEL_W-1:0];
    end

    // accumulator update, saturated to 40 bits
    always_comb
    begin
        sum_total = sum_reg + SUM_W'(prod_reg);
        acc_wide  = NACC_W'(acc_old) + NACC_W'(signed'(sum_total[SUM_W-1:FRAC_W]));
        if (acc_wide[NACC_W-1:ACC_W-1] == '0 || acc_wide[NACC_W-1:ACC_W-1] == '1)
            acc_sat = acc_wide[ACC_W-1:0];
        else if (acc_wide[NACC_W-1])
            acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
        else
            acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end

    // drive: (target + acc) * 100 / 2^16, truncated toward zero, clamped to the drive limit
    always_comb
    begin
        t_ext     = V_W'(T_W'(tgt_reg) + T_W'(acc_new_reg));
        v_abs     = v_reg[V_W-1] ? unsigned'(-v_reg) : unsigned'(v_reg);
        mag       = v_abs[V_W-1:FRAC_W];
        mag_clamp = (mag > MAG_W'(limit_reg)) ? limit_reg : mag[LIMIT_W-1:0];
        drive     = v_reg[V_W-1] ? -DRIVE_W'(mag_clamp) : DRIVE_W'(mag_clamp);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            wheel_reg <= wheel_select;
            tgt_reg   <= target_vel;
            spd_reg   <= measured_speed;
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.ld_err)
            err_reg <= err_sat;
        if (cmd.sum_clr)
            sum_reg <= SUM_W'(prod_reg);
        else if (cmd.sum_add)
            sum_reg <= sum_reg + SUM_W'(prod_reg);
        if (cmd.acc_upd)
            acc_new_reg <= acc_sat;
        if (cmd.ld_scaled)
            v_reg <= (t_ext <<< 6) + (t_ext <<< 5) + (t_ext <<< 2);
        if (cmd.ld_out)
        begin
            out_wheel_reg <= wheel_reg;
            out_drive_reg <= wheel_ok ? drive : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
            begin
                e1_reg[i]  <= '0;
                e2_reg[i]  <= '0;
                acc_reg[i] <= '0;
            end
        end
        else if (cmd.acc_upd && wheel_ok)
        begin
            acc_reg[idx] <= acc_sat;
            e2_reg[idx]  <= e1;
            e1_reg[idx]  <= err_reg;
        end
    end

    assign wheel_out        = out_wheel_reg;
    assign drive_hundredths = out_drive_reg;

endmodule

FILE: rtl/core/wheel_velocity_incremental_pid.sv
// Top level of the two-wheel incremental PID block.
// Instantiates wvip_ctrl and wvip_datapath; depends on wvip_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one request: wheel_select,
//   target_vel and measured_speed. Output channel (out_valid/out_ready)
//   returns wheel_out and drive_hundredths, one per request, in order.
//   Config port: cfg_we with cfg_index/cfg_data writes one register per
//   cycle; write only while no request is in flight.
// Steps: speed scaling, error, the three gain products, accumulator update,
//   output scaling and drive; a single multiplier is shared by the speed
//   scaling and the three gain products, one product per cycle.
// in_ready is high only while the sequencer is idle.
// Reset: clears error history and accumulators of every wheel and loads
//   the default gains, scales and drive limit.
// Stall: a finished result holds in the output register; a new request is
//   still accepted, and the sequencer waits in its last step until the
//   output register is free.
module wheel_velocity_incremental_pid
    import wvip_pkg::*;
#(
    parameter int NUM_WHEELS = NUM_WHEELS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        wheel_select,
    input  logic signed [VEL_W-1:0]     target_vel,
    input  logic signed [VEL_W-1:0]     measured_speed,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        wheel_out,
    output logic signed [DRIVE_W-1:0]   drive_hundredths,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    dp_cmd_t cmd;

    wvip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    wvip_datapath #(
        .NUM_WHEELS (NUM_WHEELS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .wheel_select     (wheel_select),
        .target_vel       (target_vel),
        .measured_speed   (measured_speed),
        .wheel_out        (wheel_out),
        .drive_hundredths (drive_hundredths)
    );

endmodule
